// ----- sv/fac_pkg.sv -----
// ----------------------------------------------------------------------------
// fac_pkg
// shared types, widths and constants of the flex angle conditioner
// ----------------------------------------------------------------------------
package fac_pkg;

    // default parameter values
    localparam int SAMPLES_PER_GROUP = 16;
    localparam int ADC_BITS          = 12;

    // fixed field widths
    localparam int SAMPLE_W = 12;
    localparam int ANGLE_W  = 7;
    localparam int LEVEL_W  = 12;
    localparam int MEAN_W   = 12;
    localparam int CAL_W    = 12;
    localparam int WEIGHT_W = 9;

    // smoother fraction bits and unity weight
    localparam int FRAC_W     = 8;
    localparam int WEIGHT_ONE = 256;

    // angle mapping
    localparam int ANGLE_MAX = 90;
    localparam int NUM_W     = CAL_W + 7;   // |level - flat| * 90
    localparam int DVS_W     = CAL_W;       // divisor width of the shared divider

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_FLAT   = 2'd0;
    localparam logic [1:0] REG_BENT   = 2'd1;
    localparam logic [1:0] REG_WEIGHT = 2'd2;

    localparam logic [CAL_W-1:0]    FLAT_RESET   = 12'd660;
    localparam logic [CAL_W-1:0]    BENT_RESET   = 12'd180;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd51;

    typedef struct packed {
        logic [CAL_W-1:0]    flat;
        logic [CAL_W-1:0]    bent;
        logic [WEIGHT_W-1:0] weight;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_ANG_SETUP,
        ST_ANG_DIV,
        ST_EMIT
    } t_state;

endpackage

// ----- sv/fac_if.sv -----
// ----------------------------------------------------------------------------
// fac_if
// valid/ready channels for sample words and result words
// ----------------------------------------------------------------------------
interface fac_in_if;
    logic                         valid;
    logic                         ready;
    logic [fac_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface fac_out_if;
    logic                        valid;
    logic                        ready;
    logic [fac_pkg::ANGLE_W-1:0] angle_deg;
    logic [fac_pkg::LEVEL_W-1:0] smoothed_level;
    logic [fac_pkg::MEAN_W-1:0]  group_mean;

    modport source (output valid, output angle_deg, output smoothed_level,
                    output group_mean, input ready);
    modport sink   (input valid, input angle_deg, input smoothed_level,
                    input group_mean, output ready);
endinterface

// ----- sv/fac_cfg.sv -----
// ----------------------------------------------------------------------------
// fac_cfg
// apb register file: flat reading, bent reading, smoothing weight
// ----------------------------------------------------------------------------
module fac_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fac_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fac_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fac_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output fac_pkg::t_cfg                      o_cfg
);

    logic [fac_pkg::CAL_W-1:0]    r_flat;
    logic [fac_pkg::CAL_W-1:0]    r_bent;
    logic [fac_pkg::WEIGHT_W-1:0] r_weight;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat   <= fac_pkg::FLAT_RESET;
            r_bent   <= fac_pkg::BENT_RESET;
            r_weight <= fac_pkg::WEIGHT_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                fac_pkg::REG_FLAT:   r_flat   <= pwdata[fac_pkg::CAL_W-1:0];
                fac_pkg::REG_BENT:   r_bent   <= pwdata[fac_pkg::CAL_W-1:0];
                fac_pkg::REG_WEIGHT: r_weight <= pwdata[fac_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fac_pkg::REG_FLAT:   prdata = fac_pkg::CFG_DATA_W'(r_flat);
            fac_pkg::REG_BENT:   prdata = fac_pkg::CFG_DATA_W'(r_bent);
            fac_pkg::REG_WEIGHT: prdata = fac_pkg::CFG_DATA_W'(r_weight);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.flat   = r_flat;
    assign o_cfg.bent   = r_bent;
    assign o_cfg.weight = r_weight;

endmodule

// ----- sv/fac_div.sv -----
// ----------------------------------------------------------------------------
// fac_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fac_div #(
    parameter int DIV_W = fac_pkg::NUM_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIV_W-1:0]              i_dividend,
    input  logic [fac_pkg::DVS_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [DIV_W-1:0]              o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;
    logic [DIV_W-1:0]          r_quo;
    logic [fac_pkg::DVS_W-1:0] r_rem;
    logic [fac_pkg::DVS_W-1:0] r_dvs;
    logic [fac_pkg::DVS_W:0]   trial;
    logic [fac_pkg::DVS_W:0]   diff;
    logic                      ge;

    // shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[fac_pkg::DVS_W-1:0] : trial[fac_pkg::DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- sv/flex_angle_conditioner_top.sv -----
// ----------------------------------------------------------------------------
// flex_angle_conditioner_top
// boxcar average, exponential smoother and linear angle calibration
// ----------------------------------------------------------------------------
// steps: a sample that does not close a group is added to the running sum; a
// closing sample passes the mean, old-share and update steps, the angle setup,
// the divider (skipped when the readings are equal or the angle falls below zero) and emit
// throughput: one sample per cycle inside a group; input busy from a closing
// sample until its word is emitted, longer while the previous result word waits
// reset: synchronous active low, clears sum, count, smoother, primed flag, word
// ----------------------------------------------------------------------------
module flex_angle_conditioner_top #(
    parameter int SAMPLES_PER_GROUP = fac_pkg::SAMPLES_PER_GROUP,
    parameter int ADC_BITS          = fac_pkg::ADC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fac_in_if.sink                         i_in,
    fac_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fac_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fac_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fac_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    // effective sample bits: the port carries 12, the converter may use fewer
    localparam int EFF_BITS = (ADC_BITS < fac_pkg::SAMPLE_W) ? ADC_BITS
                                                             : fac_pkg::SAMPLE_W;
    localparam int CNT_W  = $clog2(SAMPLES_PER_GROUP);
    localparam int SUM_W  = EFF_BITS + $clog2(SAMPLES_PER_GROUP);
    localparam int SM_W   = EFF_BITS + fac_pkg::FRAC_W;          // q.8 smoother
    localparam int PROD_W = fac_pkg::WEIGHT_W + SM_W;
    localparam int DIV_W  = fac_pkg::NUM_W;

    // floored mean by reciprocal multiply, exact for every group sum
    localparam int     MEAN_SHIFT = SUM_W + $clog2(SAMPLES_PER_GROUP);
    localparam int     RECIP_W    = SUM_W + 1;
    localparam int     MP_W       = SUM_W + RECIP_W;
    localparam longint RECIP      = ((longint'(1) << MEAN_SHIFT)
                                   + longint'(SAMPLES_PER_GROUP) - longint'(1))
                                  / longint'(SAMPLES_PER_GROUP);

    // configuration registers
    fac_pkg::t_cfg cfg;

    fac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer state
    fac_pkg::t_state r_state, n_state;

    // group accumulation
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // smoother and intermediate values
    logic [SM_W-1:0]             r_smooth, n_smooth;
    logic                        r_primed, n_primed;
    logic [EFF_BITS-1:0]         r_mean, n_mean;
    logic [PROD_W-1:0]           r_prod, n_prod;
    logic [fac_pkg::ANGLE_W-1:0] r_angle, n_angle;

    // output word register
    logic                        r_out_valid, n_out_valid;
    logic [fac_pkg::ANGLE_W-1:0] r_out_angle, n_out_angle;
    logic [fac_pkg::LEVEL_W-1:0] r_out_level, n_out_level;
    logic [fac_pkg::MEAN_W-1:0]  r_out_mean, n_out_mean;

    // shared divider hookup
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [fac_pkg::DVS_W-1:0] div_divisor;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quo;

    fac_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // shared multiplier, operands picked by the sequencer
    logic [fac_pkg::WEIGHT_W-1:0] mul_a;
    logic [SM_W-1:0]              mul_b;
    logic [PROD_W-1:0]            mul_p;

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // held group sum times the reciprocal of the group size
    logic [MP_W-1:0] mean_prod;

    assign mean_prod = MP_W'(r_prod[SUM_W-1:0]) * MP_W'(RECIP);

    // weight clamped to unity
    logic [fac_pkg::WEIGHT_W-1:0] w_eff;
    logic [fac_pkg::WEIGHT_W-1:0] w_inv;

    assign w_eff = (cfg.weight > fac_pkg::WEIGHT_W'(fac_pkg::WEIGHT_ONE))
                 ? fac_pkg::WEIGHT_W'(fac_pkg::WEIGHT_ONE) : cfg.weight;
    assign w_inv = fac_pkg::WEIGHT_W'(fac_pkg::WEIGHT_ONE) - w_eff;

    // incoming sample, upper bits beyond the converter width dropped
    logic [EFF_BITS-1:0] sample_eff;
    logic [SUM_W-1:0]    sum_add;
    logic                last_sample;

    assign sample_eff  = i_in.sample[EFF_BITS-1:0];
    assign sum_add     = r_sum + SUM_W'(sample_eff);
    assign last_sample = (r_cnt == CNT_W'(SAMPLES_PER_GROUP - 1));

    // calibration differences, 13-bit two's complement
    logic [fac_pkg::LEVEL_W-1:0] level;
    logic [fac_pkg::CAL_W:0]     diff;
    logic [fac_pkg::CAL_W:0]     span;
    logic [fac_pkg::CAL_W-1:0]   abs_diff;
    logic [fac_pkg::CAL_W-1:0]   abs_span;
    logic                        angle_zero;

    assign level    = fac_pkg::LEVEL_W'(r_smooth[SM_W-1:fac_pkg::FRAC_W]);
    assign diff     = {1'b0, level} - {1'b0, cfg.flat};
    assign span     = {1'b0, cfg.bent} - {1'b0, cfg.flat};
    assign abs_diff = diff[fac_pkg::CAL_W] ? fac_pkg::CAL_W'(-diff)
                                           : diff[fac_pkg::CAL_W-1:0];
    assign abs_span = span[fac_pkg::CAL_W] ? fac_pkg::CAL_W'(-span)
                                           : span[fac_pkg::CAL_W-1:0];
    // equal readings, or a quotient below zero
    assign angle_zero = (span == '0)
                     || ((diff != '0) && (diff[fac_pkg::CAL_W] != span[fac_pkg::CAL_W]));

    assign i_in.ready = (r_state == fac_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fac_pkg::ST_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_smooth    <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_smooth    <= n_smooth;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_mean      <= n_mean;
        r_prod      <= n_prod;
        r_angle     <= n_angle;
        r_out_angle <= n_out_angle;
        r_out_level <= n_out_level;
        r_out_mean  <= n_out_mean;
    end

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_smooth     = r_smooth;
        n_primed     = r_primed;
        n_mean       = r_mean;
        n_prod       = r_prod;
        n_angle      = r_angle;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_angle  = r_out_angle;
        n_out_level  = r_out_level;
        n_out_mean   = r_out_mean;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_a        = w_inv;
        mul_b        = r_smooth;

        case (r_state)
            fac_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    if (last_sample) begin
                        // group closed: hold the full sum for the mean step
                        n_sum   = '0;
                        n_cnt   = '0;
                        n_prod  = PROD_W'(sum_add);
                        n_state = fac_pkg::ST_MEAN;
                    end else begin
                        n_sum = sum_add;
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            fac_pkg::ST_MEAN: begin
                // floored mean from the reciprocal product
                n_mean  = mean_prod[MEAN_SHIFT +: EFF_BITS];
                n_state = fac_pkg::ST_MUL_OLD;
            end
            fac_pkg::ST_MUL_OLD: begin
                // (256 - w) * old smoother
                mul_a   = w_inv;
                mul_b   = r_smooth;
                n_prod  = mul_p;
                n_state = fac_pkg::ST_MUL_NEW;
            end
            fac_pkg::ST_MUL_NEW: begin
                // w * mean plus the old share, floored to q.8; the first group loads the mean
                mul_a = w_eff;
                mul_b = SM_W'(r_mean);
                if (r_primed) begin
                    n_smooth = SM_W'(mul_p + (r_prod >> fac_pkg::FRAC_W));
                end else begin
                    n_smooth = {r_mean, fac_pkg::FRAC_W'(0)};
                end
                n_primed = 1'b1;
                n_state  = fac_pkg::ST_ANG_SETUP;
            end
            fac_pkg::ST_ANG_SETUP: begin
                // |level - flat| * 90 over |bent - flat|
                mul_a = fac_pkg::WEIGHT_W'(fac_pkg::ANGLE_MAX);
                mul_b = SM_W'(abs_diff);
                if (angle_zero) begin
                    n_angle = '0;
                    n_state = fac_pkg::ST_EMIT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(mul_p[fac_pkg::NUM_W-1:0]);
                    div_divisor  = abs_span;
                    n_state      = fac_pkg::ST_ANG_DIV;
                end
            end
            fac_pkg::ST_ANG_DIV: begin
                if (div_done) begin
                    if (div_quo > DIV_W'(fac_pkg::ANGLE_MAX)) begin
                        n_angle = fac_pkg::ANGLE_W'(fac_pkg::ANGLE_MAX);
                    end else begin
                        n_angle = div_quo[fac_pkg::ANGLE_W-1:0];
                    end
                    n_state = fac_pkg::ST_EMIT;
                end
            end
            fac_pkg::ST_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_angle = r_angle;
                    n_out_level = level;
                    n_out_mean  = fac_pkg::MEAN_W'(r_mean);
                    n_state     = fac_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fac_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.angle_deg      = r_out_angle;
    assign o_out.smoothed_level = r_out_level;
    assign o_out.group_mean     = r_out_mean;

    // clamped angle never leaves 0..90
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_angle <= fac_pkg::ANGLE_W'(fac_pkg::ANGLE_MAX)))
        else $error("angle word above ninety degrees");

    // closing sample moves to the mean step with a fresh group
    a_group_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fac_pkg::ST_IDLE && i_in.valid && last_sample)
        |=> (r_state == fac_pkg::ST_MEAN && r_cnt == '0 && r_sum == '0))
        else $error("group close did not start the mean step");

    // divider only finishes in the mean step or while the sequencer waits on it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == fac_pkg::ST_MEAN || r_state == fac_pkg::ST_ANG_DIV))
        else $error("divider finished outside a divide step");

    // accumulator stays cleared while a closed group is processed
    a_busy_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fac_pkg::ST_IDLE) |-> (r_cnt == '0 && r_sum == '0))
        else $error("group accumulator busy during processing");

    // smoother changes only in its update step
    a_smooth_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fac_pkg::ST_MUL_NEW) |=> $stable(r_smooth))
        else $error("smoother changed outside its update step");

endmodule

// ----- sim/fac_angle_checker.sv -----
// ----------------------------------------------------------------------------
// fac_angle_checker
// watches the sample, result and register ports, predicts every result word
// and compares it field by field with what the conditioner sends
// ----------------------------------------------------------------------------
module fac_angle_checker
    import fac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fac_in_if                     i_in,
    fac_out_if                    i_out,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;
    localparam int SUM_W       = 16;
    localparam int SMOOTH_W    = LEVEL_W + FRAC_W;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [LEVEL_W-1:0] level;
        logic [MEAN_W-1:0]  mean;
    } t_angle_word;

    // predictor copy of registers and block state
    logic [CAL_W-1:0]    flat_q;
    logic [CAL_W-1:0]    bent_q;
    logic [WEIGHT_W-1:0] weight_q;
    logic [SUM_W-1:0]    group_sum_q;
    int unsigned         group_cnt_q;
    logic [SMOOTH_W-1:0] smoother_q;
    logic                primed_q;

    t_angle_word words_due[$];

    initial o_fail_count = 0;

    function automatic void log_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic logic [ANGLE_W-1:0] bend_angle(input logic [LEVEL_W-1:0] level);
        int span;
        int deg;
        span = int'(bent_q) - int'(flat_q);
        if (span == 0) return '0;
        deg = (int'(level) - int'(flat_q)) * ANGLE_MAX / span;
        if (deg < 0) deg = 0;
        if (deg > ANGLE_MAX) deg = ANGLE_MAX;
        return ANGLE_W'(deg);
    endfunction

    // add one sample; a closing sample queues the word it causes
    function automatic void take_sample(input logic [SAMPLE_W-1:0] s);
        logic [MEAN_W-1:0] mean;
        int unsigned       w;
        logic [63:0]       acc;
        t_angle_word       word;
        group_sum_q = group_sum_q + SUM_W'(s[ADC_BITS-1:0]);
        group_cnt_q++;
        if (group_cnt_q < SAMPLES_PER_GROUP) return;
        mean        = MEAN_W'(group_sum_q / SAMPLES_PER_GROUP);
        group_sum_q = '0;
        group_cnt_q = 0;
        if (!primed_q) begin
            smoother_q = {mean, {FRAC_W{1'b0}}};
            primed_q   = 1'b1;
        end else begin
            w = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
            acc = 64'(w) * 64'(mean) * 64'(WEIGHT_ONE)
                + 64'(WEIGHT_ONE - w) * 64'(smoother_q);
            smoother_q = SMOOTH_W'(acc >> FRAC_W);
        end
        word.level = smoother_q[SMOOTH_W-1:FRAC_W];
        word.angle = bend_angle(word.level);
        word.mean  = mean;
        words_due.push_back(word);
    endfunction

    always @(posedge i_clk) begin
        t_angle_word want;
        if (!i_rst_n) begin
            flat_q      = FLAT_RESET;
            bent_q      = BENT_RESET;
            weight_q    = WEIGHT_RESET;
            group_sum_q = '0;
            group_cnt_q = 0;
            smoother_q  = '0;
            primed_q    = 1'b0;
            words_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_ADDR_W-1:2])
                    REG_FLAT:   flat_q   = i_pwdata[CAL_W-1:0];
                    REG_BENT:   bent_q   = i_pwdata[CAL_W-1:0];
                    REG_WEIGHT: weight_q = i_pwdata[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) take_sample(i_in.sample);
            if (i_out.valid && i_out.ready) begin
                if (words_due.size() == 0) begin
                    log_failure($sformatf("unexpected word: angle %0d level %0d mean %0d",
                        i_out.angle_deg, i_out.smoothed_level, i_out.group_mean));
                end else begin
                    want = words_due.pop_front();
                    if (i_out.angle_deg !== want.angle
                            || i_out.smoothed_level !== want.level
                            || i_out.group_mean !== want.mean) begin
                        log_failure($sformatf(
                            "word mismatch: angle %0d/%0d level %0d/%0d mean %0d/%0d (exp/got)",
                            want.angle, i_out.angle_deg, want.level, i_out.smoothed_level,
                            want.mean, i_out.group_mean));
                    end
                end
            end
        end
        o_words_due = words_due.size();
    end

endmodule

// ----- sim/flex_angle_conditioner_top_tb.sv -----
// ----------------------------------------------------------------------------
// flex_angle_conditioner_top_tb
// drives samples and register writes into the angle conditioner over a
// series of calibration and smoothing settings, with random idling on both
// channels; a separate checker predicts and compares every result word
// ----------------------------------------------------------------------------
module flex_angle_conditioner_top_tb;
    import fac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NUM_PHASES   = 12;
    localparam int  DRAIN_CYCLES = 64;      // longer than the closing path through the divider
    localparam int  HOLD_CYCLES  = 600;     // long receiver hold-off
    localparam int  LIMIT_NS     = 2_000_000;
    localparam int  SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    localparam int  CAL_MAX      = (1 << CAL_W) - 1;
    // unused register slot, writes there must be dropped
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    fac_in_if  in_ch();
    fac_out_if out_ch();

    int fail_count;
    int words_due;

    // idling controls, set per phase by the stimulus
    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // calibration window that the sample generator aims at
    int cal_lo = 180;
    int cal_hi = 660;
    int base_level = 400;

    flex_angle_conditioner_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fac_angle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result receiver: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served  <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // run limit
    initial begin
        #LIMIT_NS;
        $display("TB_ERROR");
        $finish;
    end

    // offer one sample word, idling first at the sender's rate
    // valid stays high after acceptance so back-to-back words need no toggle
    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        logic taken;
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= value;
        // ready is settled by the falling edge and holds until the next rise
        do begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // register write: setup phase, access phase until pready, then the bus goes idle
    task automatic write_reg(input logic [1:0] index, input logic [CFG_DATA_W-1:0] value);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering, wait for every predicted word, then let the block settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (words_due != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // program all three registers; upper data bits carry junk the block must drop
    task automatic set_calibration(input int flat, input int bent, input int weight);
        write_reg(REG_FLAT,   (CFG_DATA_W'($urandom()) << CAL_W) | CFG_DATA_W'(flat));
        write_reg(REG_BENT,   (CFG_DATA_W'($urandom()) << CAL_W) | CFG_DATA_W'(bent));
        write_reg(REG_WEIGHT, (CFG_DATA_W'($urandom()) << WEIGHT_W) | CFG_DATA_W'(weight));
        cal_lo     = (flat < bent) ? flat : bent;
        cal_hi     = (flat < bent) ? bent : flat;
        base_level = (cal_lo + cal_hi) / 2;
    endtask

    // mostly noisy readings around a wandering level near the calibration
    // window, with full-range noise and rail values mixed in
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        int v;
        int lo;
        int hi;
        r = $urandom_range(99);
        if (r < 6) begin
            lo = (cal_lo > 200) ? cal_lo - 200 : 0;
            hi = (cal_hi < SAMPLE_MAX - 200) ? cal_hi + 200 : SAMPLE_MAX;
            base_level = $urandom_range(hi, lo);
        end
        if (r < 70) begin
            v = base_level + int'($urandom_range(48)) - 24;
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        end else if (r < 88) begin
            v = $urandom_range(SAMPLE_MAX);
        end else if (r < 94) begin
            v = 0;
        end else begin
            v = SAMPLE_MAX;
        end
        return SAMPLE_W'(v);
    endfunction

    initial begin
        int p;
        int n_items;
        in_ch.valid  <= 1'b0;
        in_ch.sample <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain_results();
                case (p)
                    // full-scale rising span, new mean replaces the smoother
                    1: set_calibration(0, CAL_MAX, WEIGHT_ONE);
                    // falling span, slowest smoothing
                    2: set_calibration(CAL_MAX, 0, 1);
                    // equal readings and a weight above unity
                    3: begin
                        set_calibration(1000, 1000, 300);
                        write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
                    end
                    // zero weight freezes the smoother
                    4: set_calibration(200, 3000, 0);
                    // equal readings at zero, widest weight code
                    5: set_calibration(0, 0, (1 << WEIGHT_W) - 1);
                    6: set_calibration($urandom_range(CAL_MAX), $urandom_range(CAL_MAX),
                                       $urandom_range((1 << WEIGHT_W) - 1, WEIGHT_ONE + 1));
                    11: set_calibration(CAL_MAX, CAL_MAX, WEIGHT_ONE);
                    default: set_calibration($urandom_range(CAL_MAX), $urandom_range(CAL_MAX),
                                             $urandom_range(WEIGHT_ONE, 1));
                endcase
            end

            // idling pattern: none, sender, receiver, both
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 76; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 76; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase

            if (p == 0) begin
                // rail group primes the smoother at full scale, then zeros
                repeat (16) push_sample(SAMPLE_W'(SAMPLE_MAX));
                repeat (8) push_sample('0);
            end

            // receiver holds off while samples keep coming, filling the block
            if (p == 4) hold_requests <= hold_requests + 1;

            n_items = $urandom_range(180, 140);
            repeat (n_items) push_sample(pick_sample());
        end

        drain_results();
        if (fail_count == 0 && words_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
